@@ src/dlm_pkg.sv @@
// Package for the debounced link monitor: shared types, register indexes
// and frame constants. No dependencies.
`default_nettype none
package dlm_pkg;

	localparam int        ADDR_W    = 4;
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_RETRY    = 2'd2;

	localparam logic [7:0]  DEBOUNCE_RESET = 8'd3;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
	localparam logic [15:0] RETRY_RESET    = 16'd1000;

	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'hBB;
	localparam logic [7:0] POS_IDLE   = 8'h00;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam int          TICK_W   = 17;
	localparam logic [16:0] TICK_MAX = 17'h1FFFF;

	localparam int LANES = 4;

	typedef struct packed {
		logic [7:0]  settle_frames;
		logic [15:0] silence_limit;
		logic [15:0] retry_interval;
	} cfg_t;

	typedef struct packed {
		logic             is_tick;
		logic             frame_ok;
		logic [LANES-1:0] raw;
	} item_t;

	typedef struct packed {
		logic        restart_rx;
		logic        ack_due;
		logic [15:0] retry_count;
		logic        link_up;
		logic [3:0]  stable_positions;
	} result_t;

endpackage
`default_nettype wire

@@ src/dlm_regs.sv @@
// APB-style configuration registers of the debounced link monitor.
// Depends on dlm_pkg.
`default_nettype none
module dlm_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [dlm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output dlm_pkg::cfg_t                  cfg
);

	logic        wr_en;
	logic [1:0]  reg_idx;
	dlm_pkg::cfg_t cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_frames  <= dlm_pkg::DEBOUNCE_RESET;
			cfg_q.silence_limit  <= dlm_pkg::TIMEOUT_RESET;
			cfg_q.retry_interval <= dlm_pkg::RETRY_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				dlm_pkg::REG_DEBOUNCE: cfg_q.settle_frames  <= pwdata[7:0];
				dlm_pkg::REG_TIMEOUT:  cfg_q.silence_limit  <= pwdata[15:0];
				dlm_pkg::REG_RETRY:    cfg_q.retry_interval <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dlm_pkg::REG_DEBOUNCE: prdata = {24'd0, cfg_q.settle_frames};
			dlm_pkg::REG_TIMEOUT:  prdata = {16'd0, cfg_q.silence_limit};
			dlm_pkg::REG_RETRY:    prdata = {16'd0, cfg_q.retry_interval};
			default:               prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

@@ src/dlm_front.sv @@
// Front end: classifies an incoming beat as tick, good frame or bad frame.
// Depends on dlm_pkg.
`default_nettype none
module dlm_front (
	input  wire logic        op,
	input  wire logic        length_ok,
	input  wire logic [55:0] frame_bytes,
	output dlm_pkg::item_t   item
);

	logic [7:0] first_header;
	logic [7:0] second_header;
	logic [7:0] frame_sum;
	logic [7:0] pos [dlm_pkg::LANES];
	logic [7:0] sum;

	assign first_header  = frame_bytes[7:0];
	assign second_header = frame_bytes[15:8];
	assign pos[0]        = frame_bytes[23:16];
	assign pos[1]        = frame_bytes[31:24];
	assign pos[2]        = frame_bytes[39:32];
	assign pos[3]        = frame_bytes[47:40];
	assign frame_sum     = frame_bytes[55:48];

	assign sum = first_header + second_header + pos[0] + pos[1] + pos[2] + pos[3];

	always_comb begin
		item.is_tick  = (op == dlm_pkg::OP_TICK);
		item.frame_ok = length_ok && (first_header == dlm_pkg::HDR_FIRST)
			&& (second_header == dlm_pkg::HDR_SECOND) && (sum == frame_sum);
		for (int i = 0; i < dlm_pkg::LANES; i++) begin
			item.raw[i] = (pos[i] != dlm_pkg::POS_IDLE);
		end
	end

endmodule
`default_nettype wire

@@ src/dlm_fifo.sv @@
// Two-entry queue of classified beats between front and back ends.
// Depends on dlm_pkg.
`default_nettype none
module dlm_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire dlm_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                not_empty,
	output dlm_pkg::item_t      pop_item
);

	dlm_pkg::item_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/dlm_back.sv @@
// Back end: debounce counters, link state, watchdog and retry timers, and
// the output register. Depends on dlm_pkg.
`default_nettype none
module dlm_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dlm_pkg::cfg_t  cfg,
	input  wire logic      in_valid,
	input  wire dlm_pkg::item_t in_item,
	output logic           in_pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output dlm_pkg::result_t out_result
);

	logic [7:0]  hold_q [dlm_pkg::LANES];
	logic [dlm_pkg::LANES-1:0] stable_q;
	logic        connected_q;
	logic [16:0] silence_q;
	logic [16:0] since_retry_q;
	logic [15:0] attempts_q;
	logic        out_valid_q;
	dlm_pkg::result_t out_q;

	logic [7:0]  hold_n [dlm_pkg::LANES];
	logic [dlm_pkg::LANES-1:0] stable_n;
	logic        connected_n;
	logic [16:0] silence_n;
	logic [16:0] since_retry_n;
	logic [15:0] attempts_n;
	logic        ack_n;
	logic        restart_n;
	logic [16:0] silence_inc;
	logic [16:0] since_inc;

	assign in_pop     = in_valid && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	assign silence_inc = (silence_q == dlm_pkg::TICK_MAX) ? silence_q : silence_q + 17'd1;
	assign since_inc   = (since_retry_q == dlm_pkg::TICK_MAX) ? since_retry_q
		: since_retry_q + 17'd1;

	always_comb begin
		hold_n        = hold_q;
		stable_n      = stable_q;
		connected_n   = connected_q;
		silence_n     = silence_q;
		since_retry_n = since_retry_q;
		attempts_n    = attempts_q;
		ack_n         = 1'b0;
		restart_n     = 1'b0;
		if (!in_item.is_tick) begin
			if (in_item.frame_ok) begin
				for (int i = 0; i < dlm_pkg::LANES; i++) begin
					if (cfg.settle_frames <= 8'd1) begin
						hold_n[i]   = {7'd0, in_item.raw[i]};
						stable_n[i] = in_item.raw[i];
					end else begin
						if (in_item.raw[i]) begin
							if (hold_q[i] < cfg.settle_frames) begin
								hold_n[i] = hold_q[i] + 8'd1;
							end
						end else if (hold_q[i] != 8'd0) begin
							hold_n[i] = hold_q[i] - 8'd1;
						end
						stable_n[i] = (hold_n[i] >= cfg.settle_frames);
					end
				end
				connected_n = 1'b1;
				silence_n   = '0;
				attempts_n  = '0;
				ack_n       = 1'b1;
			end
		end else begin
			silence_n     = silence_inc;
			since_retry_n = since_inc;
			if (connected_q) begin
				if (silence_inc > {1'b0, cfg.silence_limit}) begin
					connected_n   = 1'b0;
					for (int i = 0; i < dlm_pkg::LANES; i++) begin
						hold_n[i] = '0;
					end
					stable_n      = '0;
					attempts_n    = attempts_q + 16'd1;
					since_retry_n = '0;
					restart_n     = 1'b1;
				end
			end else if (since_inc >= {1'b0, cfg.retry_interval}) begin
				attempts_n    = attempts_q + 16'd1;
				since_retry_n = '0;
				restart_n     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dlm_pkg::LANES; i++) begin
				hold_q[i] <= '0;
			end
			stable_q      <= '0;
			connected_q   <= 1'b0;
			silence_q     <= '0;
			since_retry_q <= '0;
			attempts_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_pop) begin
				hold_q        <= hold_n;
				stable_q      <= stable_n;
				connected_q   <= connected_n;
				silence_q     <= silence_n;
				since_retry_q <= since_retry_n;
				attempts_q    <= attempts_n;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			out_q.stable_positions <= connected_n ? stable_n : '0;
			out_q.link_up          <= connected_n;
			out_q.retry_count      <= attempts_n;
			out_q.ack_due          <= ack_n;
			out_q.restart_rx       <= restart_n;
		end
	end

endmodule
`default_nettype wire

@@ src/debounced_link_monitor_core.sv @@
// Debounced link monitor top level: APB registers, front end, queue, back end.
// Path: the front end classifies a beat into the queue; the back end pops it
// into the output register. Throughput: one beat per cycle while m_tready is
// high; the back-end state update is the only loop.
// Reset: arst_n clears link, debounce and timer state, empties the queue and
// loads the register defaults (3, 500, 1000).
`default_nettype none
module debounced_link_monitor_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [dlm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// [7:0] first_header, [15:8] second_header, [23:16] pos_a, [31:24] pos_b,
	// [39:32] pos_c, [47:40] pos_d, [55:48] frame_sum
	input  wire logic [55:0]               s_tdata,
	// [0] op, [1] length_ok
	input  wire logic [1:0]                s_tuser,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// [3:0] stable_positions, [4] link_up, [20:5] retry_count, [21] ack_due,
	// [22] restart_rx, [23] zero
	output logic      [23:0]               m_tdata
);

	dlm_pkg::cfg_t    cfg;
	dlm_pkg::item_t   front_item;
	dlm_pkg::item_t   queue_item;
	dlm_pkg::result_t result;
	logic             queue_full;
	logic             queue_valid;
	logic             queue_pop;
	logic             push;

	assign s_tready = !queue_full;
	assign push     = s_tvalid && s_tready;
	assign m_tdata  = {1'b0, result};

	dlm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dlm_front u_front (
		.op          (s_tuser[0]),
		.length_ok   (s_tuser[1]),
		.frame_bytes (s_tdata),
		.item        (front_item)
	);

	dlm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_valid),
		.pop_item  (queue_item)
	);

	dlm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (queue_valid),
		.in_item    (queue_item),
		.in_pop     (queue_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	ack_means_up: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result.ack_due) |-> result.link_up)
		else $error("acknowledge without link up");

	ack_restart_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(result.ack_due && result.restart_rx))
		else $error("acknowledge and restart in one result");

	positions_need_link: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !result.link_up) |-> (result.stable_positions == 4'd0))
		else $error("positions reported while link down");

	restart_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result.restart_rx) |-> (result.retry_count != 16'd0
			|| $past(result.retry_count) == 16'hFFFF))
		else $error("restart without a counted attempt");

endmodule
`default_nettype wire
